>>> rtl/rmfh_pkg.sv
// Package for the recursive mutex core: types, status codes and default sizes.
package rmfh_pkg;

	localparam int DEF_QUEUE_DEPTH  = 16;
	localparam int DEF_TASK_ID_BITS = 8;
	localparam int DEF_COUNT_BITS   = 16;

	localparam int IN_DATA_W  = 8;
	localparam int STATUS_W   = 4;
	localparam int WOKEN_W    = 8;
	localparam int OWNER_W    = 8;
	localparam int COUNT_W    = 16;
	localparam int OUT_DATA_W = 40;

	typedef enum logic {
		REQ_LOCK   = 1'b0,
		REQ_UNLOCK = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED   = 4'd0,
		ST_REACQUIRED = 4'd1,
		ST_QUEUED     = 4'd2,
		ST_QFULL      = 4'd3,
		ST_OVERFLOW   = 4'd4,
		ST_NOT_OWNER  = 4'd5,
		ST_PARTIAL    = 4'd6,
		ST_FREED      = 4'd7,
		ST_HANDOVER   = 4'd8
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		status_t              status;
		logic [WOKEN_W-1:0]   woken_task;
		logic [OWNER_W-1:0]   owner_now;
		logic [COUNT_W-1:0]   count_now;
	} result_t;

endpackage

>>> rtl/rmfh_queue_ram.sv
// Wait queue storage: one write port, one registered read port.
module rmfh_queue_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rmfh_ctrl.sv
// Mutex control: owner, count and queue pointers with the request sequencer.
module rmfh_ctrl #(
	parameter int QUEUE_DEPTH  = rmfh_pkg::DEF_QUEUE_DEPTH,
	parameter int TASK_ID_BITS = rmfh_pkg::DEF_TASK_ID_BITS,
	parameter int COUNT_BITS   = rmfh_pkg::DEF_COUNT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  rmfh_pkg::req_t                 req_type,
	input  logic [TASK_ID_BITS-1:0]        req_tid,
	input  logic                           out_free,
	output logic                           res_valid,
	output rmfh_pkg::result_t              res,
	output logic                           ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
	output logic [TASK_ID_BITS-1:0]        ram_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
	input  logic [TASK_ID_BITS-1:0]        ram_rdata
);

	import rmfh_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);

	fsm_t                  state_q, state_d;
	req_t                  type_s1;
	logic [TASK_ID_BITS-1:0] tid_s1;
	logic [COUNT_BITS-1:0]   count_q, count_d;
	logic [TASK_ID_BITS-1:0] owner_q, owner_d;
	logic [QAW-1:0]          head_q, head_d;
	logic [QAW-1:0]          tail_q, tail_d;
	logic [FW-1:0]           fill_q, fill_d;
	logic                    owns;
	logic [TASK_ID_BITS-1:0] woken;
	status_t                 status;

	function automatic logic [QAW-1:0] next_slot(input logic [QAW-1:0] p);
		next_slot = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			owner_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			owner_q <= owner_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			type_s1 <= req_type;
			tid_s1  <= req_tid;
		end
	end

	assign owns = (count_q != '0) && (owner_q == tid_s1);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		owner_d   = owner_q;
		head_d    = head_q;
		tail_d    = tail_q;
		fill_d    = fill_q;
		woken     = '0;
		status    = ST_NOT_OWNER;
		req_ready = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				req_ready = out_free;
				if (req_valid && out_free) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				res_valid = 1'b1;
				state_d   = FSM_IDLE;
				if (type_s1 == REQ_LOCK) begin
					if (count_q == '0) begin
						count_d = COUNT_BITS'(1);
						owner_d = tid_s1;
						status  = ST_ACQUIRED;
					end else if (owns) begin
						if (count_q == '1) begin
							status = ST_OVERFLOW;
						end else begin
							count_d = count_q + 1'b1;
							status  = ST_REACQUIRED;
						end
					end else if (fill_q == FW'(QUEUE_DEPTH)) begin
						status = ST_QFULL;
					end else begin
						ram_we = 1'b1;
						tail_d = next_slot(tail_q);
						fill_d = fill_q + 1'b1;
						status = ST_QUEUED;
					end
				end else if (!owns) begin
					status = ST_NOT_OWNER;
				end else if (count_q != COUNT_BITS'(1)) begin
					count_d = count_q - 1'b1;
					status  = ST_PARTIAL;
				end else if (fill_q != '0) begin
					woken   = ram_rdata;
					head_d  = next_slot(head_q);
					fill_d  = fill_q - 1'b1;
					owner_d = ram_rdata;
					status  = ST_HANDOVER;
				end else begin
					count_d = '0;
					owner_d = '0;
					status  = ST_FREED;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign ram_waddr = tail_q;
	assign ram_wdata = tid_s1;
	assign ram_raddr = head_q;

	always_comb begin
		res.status     = status;
		res.woken_task = WOKEN_W'(woken);
		res.owner_now  = (count_d != '0) ? OWNER_W'(owner_d) : '0;
		res.count_now  = COUNT_W'(count_d);
	end

endmodule

>>> rtl/recursive_mutex_fifo_handoff_core.sv
// Top level of the recursive mutex with FIFO wait queue and direct handover.
//
// channel  dir  tdata                                   tuser
// s_*      in   [7:0] task_id                           [0] req_type
// m_*      out  [3:0] status [11:4] woken_task          none
//               [19:12] owner_now [35:20] count_now
//
// Each item is handled in order: the accept cycle reads the wait queue memory at
// the head pointer, then the EXEC state resolves the request and loads the output
// register. A new item is accepted back in IDLE, once the output register is free.
// Reset clears owner, count, queue pointers and fill; queue memory is not cleared.
// While a result waits in the output register with m_tready low, s_tready stays low.
module recursive_mutex_fifo_handoff_core #(
	parameter int QUEUE_DEPTH  = rmfh_pkg::DEF_QUEUE_DEPTH,
	parameter int TASK_ID_BITS = rmfh_pkg::DEF_TASK_ID_BITS,
	parameter int COUNT_BITS   = rmfh_pkg::DEF_COUNT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rmfh_pkg::IN_DATA_W-1:0]  s_tdata,  // task_id
	input  logic                            s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rmfh_pkg::OUT_DATA_W-1:0] m_tdata   // status, woken_task, owner_now, count_now
);

	import rmfh_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);

	logic                    out_valid_q;
	result_t                 out_q;
	logic                    out_free;
	logic                    res_valid;
	result_t                 res;
	logic                    ram_we;
	logic [QAW-1:0]          ram_waddr;
	logic [TASK_ID_BITS-1:0] ram_wdata;
	logic [QAW-1:0]          ram_raddr;
	logic [TASK_ID_BITS-1:0] ram_rdata;
	req_t                    req_type;
	logic [TASK_ID_BITS-1:0] req_tid;

	assign out_free = !out_valid_q || m_tready;
	assign req_type = req_t'(s_tuser);
	assign req_tid  = TASK_ID_BITS'(s_tdata);

	rmfh_queue_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (TASK_ID_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rmfh_ctrl #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS),
		.COUNT_BITS   (COUNT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_type  (req_type),
		.req_tid   (req_tid),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}},
		out_q.count_now, out_q.owner_now, out_q.woken_task, out_q.status};

endmodule

>>> sim/tb_recursive_mutex_fifo_handoff_core.sv
// Testbench for the recursive mutex core: directed and random requests against a predictor.
module tb_recursive_mutex_fifo_handoff_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rmfh_pkg::*;

	localparam int WAIT_SLOTS = DEF_QUEUE_DEPTH;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;  // task_id
	logic                  s_tuser  = 1'b0; // req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // status, woken_task, owner_now, count_now

	logic                  idle_on  = 1'b1;
	int unsigned           mismatches = 0;

	logic [COUNT_W-1:0]    held_count = '0;
	logic [OWNER_W-1:0]    holder     = '0;
	logic [OWNER_W-1:0]    waiters[$];
	result_t               outcome_q[$];

	recursive_mutex_fifo_handoff_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t mutex_outcome(req_t kind, logic [IN_DATA_W-1:0] tid);
		result_t r;
		logic    owns;
		owns = (held_count != '0) && (holder == tid);
		r.woken_task = '0;
		if (kind == REQ_LOCK) begin
			if (held_count == '0) begin
				held_count = COUNT_W'(1);
				holder = tid;
				r.status = ST_ACQUIRED;
			end else if (owns) begin
				if (held_count == '1) begin
					r.status = ST_OVERFLOW;
				end else begin
					held_count = held_count + 1'b1;
					r.status = ST_REACQUIRED;
				end
			end else if (waiters.size() >= WAIT_SLOTS) begin
				r.status = ST_QFULL;
			end else begin
				waiters.push_back(tid);
				r.status = ST_QUEUED;
			end
		end else if (!owns) begin
			r.status = ST_NOT_OWNER;
		end else begin
			held_count = held_count - 1'b1;
			if (held_count != '0) begin
				r.status = ST_PARTIAL;
			end else if (waiters.size() != 0) begin
				r.woken_task = waiters.pop_front();
				holder = r.woken_task;
				held_count = COUNT_W'(1);
				r.status = ST_HANDOVER;
			end else begin
				holder = '0;
				r.status = ST_FREED;
			end
		end
		r.owner_now = (held_count != '0) ? holder : '0;
		r.count_now = held_count;
		return r;
	endfunction

	task automatic send_req(req_t kind, logic [IN_DATA_W-1:0] tid);
		int gap;
		gap = 0;
		if (idle_on) begin
			while ($urandom_range(0, 99) < 37)
				gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= tid;
		s_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_tready);
		outcome_q.push_back(mutex_outcome(kind, tid));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= !idle_on || ($urandom_range(0, 99) >= 37);
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (outcome_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item exp none act tdata=%h", $time, m_tdata);
			end else begin
				exp_r = outcome_q.pop_front();
				if (m_tdata[3:0] != exp_r.status || m_tdata[11:4] != exp_r.woken_task ||
				    m_tdata[19:12] != exp_r.owner_now || m_tdata[35:20] != exp_r.count_now ||
				    m_tdata[39:36] != 4'd0) begin
					mismatches++;
					$display({"%0t: mismatch exp status=%0d woken=%0d owner=%0d count=%0d pad=0",
						" act status=%0d woken=%0d owner=%0d count=%0d pad=%0d"},
						$time, exp_r.status, exp_r.woken_task, exp_r.owner_now,
						exp_r.count_now, m_tdata[3:0], m_tdata[11:4], m_tdata[19:12],
						m_tdata[35:20], m_tdata[39:36]);
				end
			end
		end
	end

	task automatic test_basic();
		send_req(REQ_UNLOCK, 8'd0);
		send_req(REQ_LOCK,   8'd0);
		send_req(REQ_LOCK,   8'd0);
		send_req(REQ_UNLOCK, 8'd0);
		send_req(REQ_UNLOCK, 8'd0);
		send_req(REQ_UNLOCK, 8'd0);
		send_req(REQ_LOCK,   8'hFF);
		send_req(REQ_UNLOCK, 8'd0);
		send_req(REQ_LOCK,   8'h55);
		send_req(REQ_LOCK,   8'hAA);
		send_req(REQ_LOCK,   8'h55);
		send_req(REQ_UNLOCK, 8'hFF);
		send_req(REQ_UNLOCK, 8'h55);
		send_req(REQ_UNLOCK, 8'hAA);
		send_req(REQ_UNLOCK, 8'h55);
		wait_drained();
	endtask

	task automatic test_queue_full();
		send_req(REQ_LOCK, 8'd1);
		for (int i = 0; i < WAIT_SLOTS; i++)
			send_req(REQ_LOCK, (i % 5 == 0) ? 8'd2 : 8'($urandom_range(2, 255)));
		send_req(REQ_LOCK, 8'd200);
		send_req(REQ_LOCK, 8'd1);
		send_req(REQ_UNLOCK, 8'd1);
		while (held_count != '0)
			send_req(REQ_UNLOCK, holder);
		wait_drained();
	endtask

	task automatic test_deep_recursion();
		idle_on = 1'b0;
		send_req(REQ_LOCK, 8'd7);
		repeat (60)
			send_req(REQ_LOCK, 8'd7);
		send_req(REQ_LOCK, 8'd9);
		send_req(REQ_LOCK, 8'd0);
		while (held_count != '0)
			send_req(REQ_UNLOCK, holder);
		wait_drained();
		idle_on = 1'b1;
	endtask

	task automatic test_random(int n_items, int lock_pct);
		logic [IN_DATA_W-1:0] pool[4];
		logic [IN_DATA_W-1:0] tid;
		int                   pick;
		req_t                 kind;
		pool[0] = 8'd0;
		pool[1] = 8'hFF;
		pool[2] = 8'($urandom_range(0, 255));
		pool[3] = 8'($urandom_range(0, 255));
		for (int i = 0; i < n_items; i++) begin
			kind = ($urandom_range(0, 99) < lock_pct) ? REQ_LOCK : REQ_UNLOCK;
			pick = $urandom_range(0, 99);
			if (held_count != '0 && pick < 50)
				tid = holder;
			else if (pick < 85)
				tid = pool[$urandom_range(0, 3)];
			else
				tid = 8'($urandom_range(0, 255));
			send_req(kind, tid);
		end
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic();
		test_queue_full();
		test_deep_recursion();
		test_random(140, 70);
		test_random(140, 30);
		test_random(140, 85);
		test_random(140, 50);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rmfh_pkg.sv
rtl/rmfh_queue_ram.sv
rtl/rmfh_ctrl.sv
rtl/recursive_mutex_fifo_handoff_core.sv
sim/tb_recursive_mutex_fifo_handoff_core.sv
